// ===== design/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int KIND_W    = 3;
   localparam int BYTE_W    = 8;
   localparam int COORD_W   = 8;
   localparam int OUT_COL_W = 7;
   localparam int OUT_ROW_W = 5;
   localparam int CELL_W    = 16;
   localparam int CSR_IDX_W = 1;

   typedef logic [KIND_W-1:0]  kind_type;
   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [CELL_W-1:0]  cell_type;

   localparam kind_type K_POS   = 3'd0;
   localparam kind_type K_CUR   = 3'd1;
   localparam kind_type K_BS    = 3'd2;
   localparam kind_type K_CLEAR = 3'd3;
   localparam kind_type K_READ  = 3'd4;

   localparam byte_type CH_NEWLINE   = 8'd10;
   localparam byte_type CH_BACKSPACE = 8'd8;
   localparam byte_type CH_ERROR     = 8'd69;
   localparam byte_type CH_SPACE     = 8'd32;

   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_ATTR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_ATTR   = 1'd1;

   localparam byte_type DEFAULT_ATTR_RST = 8'd15;
   localparam byte_type ERROR_ATTR_RST   = 8'd244;

endpackage

// ===== design/text_console_writer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode console: screen store of character/attribute cells and a cursor.
//
// Request channel (req_*): one item prints at a position, prints at the
// cursor, backspaces, clears the screen or reads one cell. The block takes
// one item at a time; req_stall is low only while it waits for an item.
// Response channel (rsp_*): exactly one item per request, giving the cursor
// afterwards, the error flag and the read cell. A finished response waits in
// an output register, so the next request is taken while it is stalled.
// Steps: an accepted item passes ST_ADDR and ST_EXEC, then ST_RESP loads
// the response register; an on-screen read first passes ST_RDWAIT, a
// clear ST_CLEAR and a scrolling print ST_SCROLL and ST_SFLUSH, as every
// cell moves through the single read and write port of the screen memory,
// one cell per cycle. A new request is taken once the response can be.
// Reset: the cursor homes, the attributes return to their defaults, and a
// clearing pass zeroes every cell of the screen memory; no request is
// taken during that pass. csr_* writes are taken at any time.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              csr_write_en,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tcw_pkg::BYTE_W-1:0]        csr_wdata,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [tcw_pkg::KIND_W-1:0]        req_kind,
   input  logic [tcw_pkg::BYTE_W-1:0]        req_char_code,
   input  logic [tcw_pkg::COORD_W-1:0]       req_col,
   input  logic [tcw_pkg::COORD_W-1:0]       req_row,
   input  logic [tcw_pkg::BYTE_W-1:0]        req_attr,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tcw_pkg::OUT_COL_W-1:0]     rsp_cursor_col,
   output logic [tcw_pkg::OUT_ROW_W-1:0]     rsp_cursor_row,
   output logic                              rsp_error,
   output logic [tcw_pkg::BYTE_W-1:0]        rsp_cell_char,
   output logic [tcw_pkg::BYTE_W-1:0]        rsp_cell_attr
);

   import tcw_pkg::*;

   localparam int CELLS = COLS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int LW    = 2 * COORD_W;

   typedef logic [AW-1:0] addr_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_ADDR,
      ST_EXEC,
      ST_CLEAR,
      ST_SCROLL,
      ST_SFLUSH,
      ST_RDWAIT,
      ST_RESP
   } state_type;

   state_type state_ff;

   byte_type  default_attr_ff;
   byte_type  error_attr_ff;

   kind_type  kind_ff;
   byte_type  char_ff;
   coord_type col_ff;
   coord_type row_ff;
   byte_type  attr_ff;

   coord_type cur_col_ff;
   coord_type cur_row_ff;
   coord_type tcol_ff;
   coord_type trow_ff;
   addr_type  pos_ff;
   logic      inside_ff;
   addr_type  k_ff;

   logic      pw_valid_ff;
   logic      pw_move_ff;
   addr_type  pw_addr_ff;

   logic      err_ff;
   byte_type  rc_ff;
   byte_type  ra_ff;

   logic                 rsp_valid_ff;
   logic [OUT_COL_W-1:0] rsp_col_ff;
   logic [OUT_ROW_W-1:0] rsp_row_ff;
   logic                 rsp_err_ff;
   byte_type             rsp_char_ff;
   byte_type             rsp_attr_ff;

   cell_type  mem [CELLS];
   cell_type  rdata_ff;
   addr_type  mem_raddr;
   logic      mem_we;
   addr_type  mem_waddr;
   cell_type  mem_wdata;

   coord_type      tcol_in;
   coord_type      trow_in;
   logic [LW-1:0]  lin;
   addr_type       pos_in;
   logic           inside_in;

   byte_type  ch_eff;
   byte_type  at_eff;
   logic      is_put;
   logic      wr_cell;
   coord_type ncol_in;
   coord_type nrow_in;
   logic      scroll_need;

   // target cell of the item
   always_comb begin
      tcol_in = col_ff;
      trow_in = row_ff;
      unique case (kind_ff)
         K_CUR: begin
            tcol_in = cur_col_ff;
            trow_in = cur_row_ff;
         end
         K_BS: begin
            if (cur_col_ff != '0) begin
               tcol_in = cur_col_ff - 1'b1;
               trow_in = cur_row_ff;
            end else if (cur_row_ff != '0) begin
               tcol_in = COORD_W'(COLS - 1);
               trow_in = cur_row_ff - 1'b1;
            end else begin
               tcol_in = '0;
               trow_in = '0;
            end
         end
         default: begin
            tcol_in = col_ff;
            trow_in = row_ff;
         end
      endcase
      lin       = LW'(trow_in) * LW'(COLS) + LW'(tcol_in);
      pos_in    = lin[AW-1:0];
      inside_in = (col_ff < COORD_W'(COLS)) && (row_ff < COORD_W'(ROWS));
   end

   // print step: cell write and next cursor
   always_comb begin
      ch_eff  = (kind_ff == K_BS) ? CH_BACKSPACE : char_ff;
      at_eff  = (kind_ff == K_BS) ? default_attr_ff : attr_ff;
      is_put  = ((kind_ff == K_POS) && inside_ff) || (kind_ff == K_CUR) ||
                (kind_ff == K_BS);
      wr_cell = (ch_eff != CH_NEWLINE);
      ncol_in = tcol_ff;
      nrow_in = trow_ff;
      priority if (ch_eff == CH_NEWLINE) begin
         ncol_in = '0;
         nrow_in = trow_ff + 1'b1;
      end else if (ch_eff == CH_BACKSPACE) begin
         ncol_in = tcol_ff;
         nrow_in = trow_ff;
      end else if (tcol_ff == COORD_W'(COLS - 1)) begin
         ncol_in = '0;
         nrow_in = trow_ff + 1'b1;
      end else begin
         ncol_in = tcol_ff + 1'b1;
         nrow_in = trow_ff;
      end
      scroll_need = (nrow_in == COORD_W'(ROWS));
   end

   // memory port control
   always_comb begin
      mem_raddr = (state_ff == ST_SCROLL) ? (k_ff + AW'(COLS)) : pos_ff;
      mem_we    = 1'b0;
      mem_waddr = pos_ff;
      mem_wdata = {at_eff, (ch_eff == CH_BACKSPACE) ? CH_SPACE : ch_eff};
      if (pw_valid_ff) begin
         mem_we    = 1'b1;
         mem_waddr = pw_addr_ff;
         mem_wdata = pw_move_ff ? rdata_ff : '0;
      end else begin
         unique case (state_ff)
            ST_INIT: begin
               mem_we    = 1'b1;
               mem_waddr = k_ff;
               mem_wdata = '0;
            end
            ST_CLEAR: begin
               mem_we    = 1'b1;
               mem_waddr = k_ff;
               mem_wdata = {default_attr_ff, CH_SPACE};
            end
            ST_EXEC: begin
               if ((kind_ff == K_POS) && !inside_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = AW'(CELLS - 1);
                  mem_wdata = {error_attr_ff, CH_ERROR};
               end else if (is_put && wr_cell) begin
                  mem_we = 1'b1;
               end
            end
            default: begin
               mem_we = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_INIT;
         default_attr_ff <= DEFAULT_ATTR_RST;
         error_attr_ff   <= ERROR_ATTR_RST;
         cur_col_ff      <= '0;
         cur_row_ff      <= '0;
         k_ff            <= '0;
         pw_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_DEFAULT_ATTR: default_attr_ff <= csr_wdata;
               CSR_ERROR_ATTR:   error_attr_ff   <= csr_wdata;
               default:          ;
            endcase
         end

         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_RESP)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_INIT: begin
               k_ff <= k_ff + 1'b1;
               if (k_ff == AW'(CELLS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  kind_ff  <= req_kind;
                  char_ff  <= req_char_code;
                  col_ff   <= req_col;
                  row_ff   <= req_row;
                  attr_ff  <= (req_attr == '0) ? default_attr_ff : req_attr;
                  err_ff   <= 1'b0;
                  rc_ff    <= '0;
                  ra_ff    <= '0;
                  state_ff <= ST_ADDR;
               end
            end
            ST_ADDR: begin
               tcol_ff   <= tcol_in;
               trow_ff   <= trow_in;
               pos_ff    <= pos_in;
               inside_ff <= inside_in;
               state_ff  <= ST_EXEC;
            end
            ST_EXEC: begin
               k_ff <= '0;
               if (is_put) begin
                  if (scroll_need) begin
                     cur_col_ff <= '0;
                     cur_row_ff <= COORD_W'(ROWS - 1);
                     state_ff   <= ST_SCROLL;
                  end else begin
                     cur_col_ff <= ncol_in;
                     cur_row_ff <= nrow_in;
                     state_ff   <= ST_RESP;
                  end
               end else begin
                  unique case (kind_ff)
                     K_POS: begin
                        err_ff   <= 1'b1;
                        state_ff <= ST_RESP;
                     end
                     K_CLEAR: begin
                        cur_col_ff <= '0;
                        cur_row_ff <= '0;
                        state_ff   <= ST_CLEAR;
                     end
                     K_READ: begin
                        if (inside_ff) begin
                           state_ff <= ST_RDWAIT;
                        end else begin
                           err_ff   <= 1'b1;
                           state_ff <= ST_RESP;
                        end
                     end
                     default: begin
                        state_ff <= ST_RESP;
                     end
                  endcase
               end
            end
            ST_CLEAR: begin
               k_ff <= k_ff + 1'b1;
               if (k_ff == AW'(CELLS - 1)) begin
                  state_ff <= ST_RESP;
               end
            end
            ST_SCROLL: begin
               pw_valid_ff <= 1'b1;
               pw_addr_ff  <= k_ff;
               pw_move_ff  <= (k_ff < AW'(CELLS - COLS));
               k_ff        <= k_ff + 1'b1;
               if (k_ff == AW'(CELLS - 1)) begin
                  state_ff <= ST_SFLUSH;
               end
            end
            ST_SFLUSH: begin
               pw_valid_ff <= 1'b0;
               state_ff    <= ST_RESP;
            end
            ST_RDWAIT: begin
               rc_ff    <= rdata_ff[BYTE_W-1:0];
               ra_ff    <= rdata_ff[CELL_W-1:BYTE_W];
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_col_ff   <= cur_col_ff[OUT_COL_W-1:0];
                  rsp_row_ff   <= cur_row_ff[OUT_ROW_W-1:0];
                  rsp_err_ff   <= err_ff;
                  rsp_char_ff  <= rc_ff;
                  rsp_attr_ff  <= ra_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_error      = rsp_err_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_attr  = rsp_attr_ff;

`ifndef ASSERT_OFF
   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      (cur_col_ff < COORD_W'(COLS)) && (cur_row_ff < COORD_W'(ROWS)))
      else $error("cursor left the screen");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_we)
      else $error("screen written while idle");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESP))
      else $error("response raised outside the response step");
`endif

endmodule

// ===== bench/console_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_checker
// Watches the request, response and register ports of the text console
// writer. It keeps its own screen, cursor and attribute registers, predicts
// the response of every accepted request and compares each accepted response
// field by field, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module console_checker #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              csr_write_en,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tcw_pkg::BYTE_W-1:0]        csr_wdata,

   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [tcw_pkg::KIND_W-1:0]        req_kind,
   input  logic [tcw_pkg::BYTE_W-1:0]        req_char_code,
   input  logic [tcw_pkg::COORD_W-1:0]       req_col,
   input  logic [tcw_pkg::COORD_W-1:0]       req_row,
   input  logic [tcw_pkg::BYTE_W-1:0]        req_attr,

   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [tcw_pkg::OUT_COL_W-1:0]     rsp_cursor_col,
   input  logic [tcw_pkg::OUT_ROW_W-1:0]     rsp_cursor_row,
   input  logic                              rsp_error,
   input  logic [tcw_pkg::BYTE_W-1:0]        rsp_cell_char,
   input  logic [tcw_pkg::BYTE_W-1:0]        rsp_cell_attr,

   output int                                mismatch_count,
   output int                                rsps_outstanding
);
   import tcw_pkg::*;

   localparam int CELLS = COLS * ROWS;

   typedef struct packed {
      logic [OUT_COL_W-1:0] cursor_col;
      logic [OUT_ROW_W-1:0] cursor_row;
      logic                 error;
      byte_type             cell_char;
      byte_type             cell_attr;
   } console_rsp_type;

   cell_type        screen_mem [CELLS];
   int unsigned     cursor_pos;
   byte_type        default_attr;
   byte_type        error_attr;
   console_rsp_type predicted_rsps [$];

   task automatic report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic compare_field(string name, int got, int want);
      if (got != want) report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, want));
   endtask

   // print one byte at a cell and move the cursor, scrolling past the end
   function automatic void write_char(int unsigned pos, byte_type ch, byte_type at);
      int unsigned next_pos;
      if (ch == CH_NEWLINE) begin
         next_pos = (pos / COLS + 1) * COLS;
      end else if (ch == CH_BACKSPACE) begin
         screen_mem[pos] = {at, CH_SPACE};
         next_pos = pos;
      end else begin
         screen_mem[pos] = {at, ch};
         next_pos = pos + 1;
      end
      if (next_pos >= CELLS) begin
         for (int i = 0; i < CELLS - COLS; i++) screen_mem[i] = screen_mem[i + COLS];
         for (int i = CELLS - COLS; i < CELLS; i++) screen_mem[i] = '0;
         next_pos -= COLS;
      end
      cursor_pos = next_pos;
   endfunction

   function automatic console_rsp_type predict_console(kind_type kind, byte_type ch,
                                                       coord_type col, coord_type row,
                                                       byte_type attr);
      console_rsp_type rsp;
      byte_type        at;
      logic            on_screen;
      int unsigned     cell_pos;
      int unsigned     cur_col;
      int unsigned     cur_row;
      rsp = '0;
      at = (attr == '0) ? default_attr : attr;
      on_screen = (int'(col) < COLS) && (int'(row) < ROWS);
      cell_pos = int'(row) * COLS + int'(col);
      if (cursor_pos >= CELLS) cursor_pos = 0;
      case (kind)
         K_POS: begin
            if (on_screen) begin
               write_char(cell_pos, ch, at);
            end else begin
               screen_mem[CELLS - 1] = {error_attr, CH_ERROR};
               rsp.error = 1'b1;
            end
         end
         K_CUR: begin
            write_char(cursor_pos, ch, at);
         end
         K_BS: begin
            write_char((cursor_pos == 0) ? 0 : cursor_pos - 1, CH_BACKSPACE, default_attr);
         end
         K_CLEAR: begin
            for (int i = 0; i < CELLS; i++) screen_mem[i] = {default_attr, CH_SPACE};
            cursor_pos = 0;
         end
         K_READ: begin
            if (on_screen) begin
               rsp.cell_char = screen_mem[cell_pos][7:0];
               rsp.cell_attr = screen_mem[cell_pos][15:8];
            end else begin
               rsp.error = 1'b1;
            end
         end
         default: begin
         end
      endcase
      cur_col = cursor_pos % COLS;
      cur_row = cursor_pos / COLS;
      rsp.cursor_col = cur_col[OUT_COL_W-1:0];
      rsp.cursor_row = cur_row[OUT_ROW_W-1:0];
      return rsp;
   endfunction

   always @(posedge clock) begin
      console_rsp_type want;
      if (reset) begin
         for (int i = 0; i < CELLS; i++) screen_mem[i] = '0;
         cursor_pos   = 0;
         default_attr = DEFAULT_ATTR_RST;
         error_attr   = ERROR_ATTR_RST;
         predicted_rsps.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_DEFAULT_ATTR) default_attr = csr_wdata;
            else if (csr_index == CSR_ERROR_ATTR) error_attr = csr_wdata;
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsps.size() == 0) begin
               report_mismatch("response item with no request item waiting");
            end else begin
               want = predicted_rsps.pop_front();
               compare_field("cursor_col", rsp_cursor_col, want.cursor_col);
               compare_field("cursor_row", rsp_cursor_row, want.cursor_row);
               compare_field("error", rsp_error, want.error);
               compare_field("cell_char", rsp_cell_char, want.cell_char);
               compare_field("cell_attr", rsp_cell_attr, want.cell_attr);
            end
         end
         if (req_valid && !req_stall) begin
            predicted_rsps.push_back(predict_console(req_kind, req_char_code, req_col,
                                                     req_row, req_attr));
         end
      end
      rsps_outstanding = predicted_rsps.size();
   end

endmodule

// ===== bench/tb_text_console_writer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer_unit
// Drives the text console writer with a directed set of corner items and
// then random print, backspace, clear, read and unused-kind items under three
// attribute settings and three patterns of sender and receiver idling. A
// checker beside the block predicts and compares every response item.
// ----------------------------------------------------------------------------
module tb_text_console_writer_unit;
   import tcw_pkg::*;

   localparam int SCREEN_COLS = 80;
   localparam int SCREEN_ROWS = 25;

   logic                    clock         = 1'b0;
   logic                    reset         = 1'b1;
   logic                    csr_write_en  = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index     = CSR_DEFAULT_ATTR;
   byte_type                csr_wdata     = '0;
   logic                    req_valid     = 1'b0;
   logic                    req_stall;
   kind_type                req_kind      = K_POS;
   byte_type                req_char_code = '0;
   coord_type               req_col       = '0;
   coord_type               req_row       = '0;
   byte_type                req_attr      = '0;
   logic                    rsp_valid;
   logic                    rsp_stall     = 1'b0;
   logic [OUT_COL_W-1:0]    rsp_cursor_col;
   logic [OUT_ROW_W-1:0]    rsp_cursor_row;
   logic                    rsp_error;
   byte_type                rsp_cell_char;
   byte_type                rsp_cell_attr;
   int                      mismatch_count;
   int                      rsps_outstanding;

   int                      send_idle_pct = 34;
   int                      recv_idle_pct = 86;
   coord_type               last_col      = '0;
   coord_type               last_row      = '0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   text_console_writer_unit #(
      .COLS(SCREEN_COLS),
      .ROWS(SCREEN_ROWS)
   ) uut (
      .clock(clock), .reset(reset),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_char_code(req_char_code), .req_col(req_col), .req_row(req_row),
      .req_attr(req_attr),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_cursor_col(rsp_cursor_col),
      .rsp_cursor_row(rsp_cursor_row), .rsp_error(rsp_error),
      .rsp_cell_char(rsp_cell_char), .rsp_cell_attr(rsp_cell_attr)
   );

   console_checker #(
      .COLS(SCREEN_COLS),
      .ROWS(SCREEN_ROWS)
   ) chk (
      .clock(clock), .reset(reset),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_char_code(req_char_code), .req_col(req_col), .req_row(req_row),
      .req_attr(req_attr),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_cursor_col(rsp_cursor_col),
      .rsp_cursor_row(rsp_cursor_row), .rsp_error(rsp_error),
      .rsp_cell_char(rsp_cell_char), .rsp_cell_attr(rsp_cell_attr),
      .mismatch_count(mismatch_count), .rsps_outstanding(rsps_outstanding)
   );

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // entered and left at a falling edge; valid stays high after acceptance
   task automatic send_item(kind_type k, byte_type ch, coord_type c, coord_type r,
                            byte_type at);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= k;
      req_char_code <= ch;
      req_col       <= c;
      req_row       <= r;
      req_attr      <= at;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_console();
      req_valid <= 1'b0;
      @(negedge clock);
      while (rsps_outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_attrs(byte_type dflt, byte_type err);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_DEFAULT_ATTR;
      csr_wdata    <= dflt;
      @(negedge clock);
      csr_index    <= CSR_ERROR_ATTR;
      csr_wdata    <= err;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_item();
      int unsigned sel;
      kind_type    k;
      byte_type    ch;
      byte_type    at;
      coord_type   c;
      coord_type   r;
      sel = $urandom_range(0, 99);
      if (sel < 28) k = K_POS;
      else if (sel < 58) k = K_CUR;
      else if (sel < 68) k = K_BS;
      else if (sel < 70) k = K_CLEAR;
      else if (sel < 96) k = K_READ;
      else k = K_READ + kind_type'($urandom_range(1, 3));
      sel = $urandom_range(0, 99);
      if (sel < 8) ch = CH_NEWLINE;
      else if (sel < 13) ch = CH_BACKSPACE;
      else if (sel < 16) ch = CH_SPACE;
      else ch = byte_type'($urandom_range(0, 255));
      at = ($urandom_range(0, 3) == 0) ? '0 : byte_type'($urandom_range(0, 255));
      c = coord_type'($urandom_range(0, 255));
      r = coord_type'($urandom_range(0, 255));
      sel = $urandom_range(0, 99);
      if (k == K_POS && sel < 88) begin
         c = coord_type'($urandom_range(0, SCREEN_COLS - 1));
         if ($urandom_range(0, 99) < 15) r = coord_type'(SCREEN_ROWS - 1);
         else r = coord_type'($urandom_range(0, SCREEN_ROWS - 1));
         last_col = c;
         last_row = r;
      end else if (k == K_POS && sel < 94) begin
         c = coord_type'($urandom_range(SCREEN_COLS, 255));
      end else if (k == K_POS) begin
         r = coord_type'($urandom_range(SCREEN_ROWS, 255));
      end else if (k == K_READ && sel < 40) begin
         c = last_col;
         r = last_row;
      end else if (k == K_READ && sel < 90) begin
         c = coord_type'($urandom_range(0, SCREEN_COLS - 1));
         r = coord_type'($urandom_range(0, SCREEN_ROWS - 1));
      end
      send_item(k, ch, c, r, at);
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      set_attrs(DEFAULT_ATTR_RST, ERROR_ATTR_RST);

      // corner items
      send_item(K_READ, 8'h00, 8'd0, 8'd0, 8'h00);
      send_item(K_POS, "A", 8'd0, 8'd0, 8'h00);
      send_item(K_READ, 8'hFF, 8'd0, 8'd0, 8'hFF);
      send_item(K_POS, 8'hFF, 8'd79, 8'd24, 8'hFF);
      send_item(K_READ, 8'h00, 8'd79, 8'd23, 8'h00);
      send_item(K_POS, CH_NEWLINE, 8'd5, 8'd24, 8'h01);
      send_item(K_POS, CH_BACKSPACE, 8'd10, 8'd3, 8'h80);
      send_item(K_READ, 8'h00, 8'd10, 8'd3, 8'h00);
      send_item(K_POS, "x", 8'd80, 8'd0, 8'h00);
      send_item(K_POS, "x", 8'd0, 8'd25, 8'h00);
      send_item(K_POS, 8'h00, 8'd255, 8'd255, 8'hFF);
      send_item(K_READ, 8'h00, 8'd79, 8'd24, 8'h00);
      send_item(K_READ, 8'h00, 8'd80, 8'd24, 8'h00);
      send_item(K_READ, 8'h00, 8'd0, 8'd255, 8'h00);
      send_item(K_CUR, 8'h00, 8'd255, 8'd255, 8'h01);
      send_item(K_CUR, CH_NEWLINE, 8'd0, 8'd0, 8'h00);
      send_item(K_CUR, CH_BACKSPACE, 8'd0, 8'd0, 8'h7F);
      send_item(K_BS, 8'hFF, 8'd255, 8'd255, 8'hFF);
      send_item(K_CLEAR, 8'hFF, 8'd255, 8'd255, 8'hFF);
      send_item(K_BS, 8'h00, 8'd0, 8'd0, 8'h00);
      send_item(K_READ, 8'h00, 8'd0, 8'd0, 8'h00);
      for (int n = 1; n <= 3; n++) begin
         send_item(K_READ + kind_type'(n), 8'hA5, 8'd3, 8'd4, 8'h5A);
      end
      send_item(K_CUR, "Z", 8'd0, 8'd0, 8'h00);

      drain_console();
      set_attrs(8'h00, 8'hFF);
      repeat (100) random_item();

      drain_console();
      send_idle_pct = 86;
      recv_idle_pct = 34;
      set_attrs(8'hFF, 8'h00);
      repeat (100) random_item();

      drain_console();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_attrs(byte_type'($urandom_range(1, 254)), byte_type'($urandom_range(1, 254)));
      repeat (100) random_item();

      drain_console();
      if (mismatch_count == 0 && rsps_outstanding == 0) begin
         $display("tb_text_console_writer_unit passed");
      end else begin
         $display("tb_text_console_writer_unit failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb_text_console_writer_unit failed");
      $finish;
   end

endmodule
